// File: hdl/lru_unit_allocator_defines.svh
// assertion macros for the lru unit allocator
`ifndef LRU_UNIT_ALLOCATOR_DEFINES_SVH
`define LRU_UNIT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// checked on every edge outside reset
`define LUA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lua assertion failed");
// checked on every edge, reset included
`define LUA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("lua assertion failed");
`else
`define LUA_ASSERT(name, prop)
`define LUA_ASSERT_ALWAYS(name, prop)
`endif

`endif

// File: hdl/lua_pkg.sv
package lua_pkg;

  // pool and field sizes
  localparam int UNITS    = 16;
  localparam int UNIT_W   = $clog2(UNITS);
  localparam int CNT_W    = UNIT_W + 1;
  localparam int ID_W     = 16;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  // request codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_USE         = 2'd0,
    FUNC_RELEASE     = 2'd1,
    FUNC_RELEASE_ALL = 2'd2,
    FUNC_NOP         = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NOT_INIT   = 2'd1,
    STATUS_NOT_LOADED = 2'd2
  } status_e;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_REPORT,
    OP_REFILL,
    OP_TOUCH,
    OP_LOAD_FREE,
    OP_EVICT,
    OP_RELEASE
  } op_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC,
    ST_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    lookup;
    logic    cfg_write;
    op_e     op;
    status_e status;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    func_e func;
    logic  not_init;
    logic  hit;
    logic  stack_empty;
  } dp_stat_t;

endpackage

// File: hdl/lua_ctrl.sv
`include "lru_unit_allocator_defines.svh"

module lua_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  lua_pkg::dp_stat_t  stat_i,
  output lua_pkg::ctrl_cmd_t cmd_o,
  output logic               done_o
);
  import lua_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = ST_EXEC;
      ST_EXEC:   state_d = ST_RESP;
      ST_RESP:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs and operation decode
  always_comb begin
    busy          = (state_q != ST_IDLE);
    cfg_ready_o   = (state_q == ST_IDLE) && !start;
    done_o        = (state_q == ST_RESP);
    cmd_o.capture   = (state_q == ST_IDLE) && start;
    cmd_o.lookup    = (state_q == ST_LOOKUP);
    cmd_o.cfg_write = cfg_valid_i && cfg_ready_o;
    cmd_o.op        = OP_IDLE;
    cmd_o.status    = STATUS_OK;
    case (state_q)
      ST_EXEC: begin
        if (stat_i.func == FUNC_NOP) begin
          cmd_o.op = OP_REPORT;
        end else if (stat_i.not_init) begin
          cmd_o.op     = OP_REPORT;
          cmd_o.status = STATUS_NOT_INIT;
        end else if (stat_i.func == FUNC_RELEASE_ALL) begin
          cmd_o.op = OP_REFILL;
        end else if (stat_i.func == FUNC_RELEASE) begin
          if (stat_i.hit) begin
            cmd_o.op = OP_RELEASE;
          end else begin
            cmd_o.op     = OP_REPORT;
            cmd_o.status = STATUS_NOT_LOADED;
          end
        end else if (stat_i.hit) begin
          cmd_o.op = OP_TOUCH;
        end else if (stat_i.stack_empty) begin
          cmd_o.op = OP_EVICT;
        end else begin
          cmd_o.op = OP_LOAD_FREE;
        end
      end
      default: begin
        cmd_o.op = OP_IDLE;
      end
    endcase
  end

  `LUA_ASSERT(a_done_single, done_o |=> !done_o)
  `LUA_ASSERT(a_accept_to_done, (start && !busy) |=> ##2 done_o)

endmodule

// File: hdl/lua_datapath.sv
`include "lru_unit_allocator_defines.svh"

module lua_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lua_pkg::FUNC_W-1:0]     func_i,
  input  logic [lua_pkg::ID_W-1:0]       texture_id_i,
  input  logic [lua_pkg::CNT_W-1:0]      cfg_units_i,
  input  lua_pkg::ctrl_cmd_t             cmd_i,
  output lua_pkg::dp_stat_t              stat_o,
  output logic [lua_pkg::UNIT_W-1:0]     unit_o,
  output logic                           hit_o,
  output logic                           evicted_o,
  output logic [lua_pkg::ID_W-1:0]       evicted_texture_o,
  output logic [lua_pkg::STATUS_W-1:0]   status_o
);
  import lua_pkg::*;

  // request word
  func_e              func_q;
  logic [ID_W-1:0]    id_q;

  // allocator state
  logic [ID_W-1:0]    tex_q   [UNITS];
  logic [UNIT_W-1:0]  rank_q  [UNITS];
  logic [UNIT_W-1:0]  rank_d  [UNITS];
  logic [UNIT_W-1:0]  stack_q [UNITS];
  logic [UNITS-1:0]   loaded_q, loaded_d;
  logic [CNT_W-1:0]   free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0]   units_q, units_d;

  // lookup results
  logic [UNITS-1:0]   hit_vec, lru_vec;
  logic [UNIT_W-1:0]  hit_idx_c, lru_idx_c;
  logic [UNIT_W-1:0]  hit_idx_q, lru_idx_q;
  logic               hit_any_q;

  // execute helpers
  logic               refill;
  logic [CNT_W-1:0]   fill_n;
  logic [CNT_W-1:0]   cfg_capped;
  logic [CNT_W-1:0]   top_cnt;
  logic [UNIT_W-1:0]  last_rank;
  logic [UNIT_W-1:0]  tgt;
  logic [UNIT_W-1:0]  tgt_rank;
  logic               push_ok;

  // result word
  logic [UNIT_W-1:0]   unit_q;
  logic                hit_q, ev_q;
  logic [ID_W-1:0]     evtex_q;
  logic [STATUS_W-1:0] status_q;

  assign cfg_capped = (cfg_units_i > CNT_W'(UNITS)) ? CNT_W'(UNITS) : cfg_units_i;
  assign refill     = cmd_i.cfg_write || (cmd_i.op == OP_REFILL);
  assign fill_n     = cmd_i.cfg_write ? cfg_capped : units_q;
  assign top_cnt    = free_cnt_q - CNT_W'(1);
  assign last_rank  = UNIT_W'(units_q - CNT_W'(1));
  assign push_ok    = (free_cnt_q < CNT_W'(UNITS));

  // parallel tag and oldest-rank match
  always_comb begin
    hit_idx_c = '0;
    lru_idx_c = '0;
    for (int i = 0; i < UNITS; i++) begin
      hit_vec[i] = loaded_q[i] && (tex_q[i] == id_q);
      lru_vec[i] = loaded_q[i] && (rank_q[i] == last_rank);
    end
    for (int i = UNITS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx_c = UNIT_W'(i);
      if (lru_vec[i]) lru_idx_c = UNIT_W'(i);
    end
  end

  // unit the operation works on
  always_comb begin
    case (cmd_i.op)
      OP_EVICT:     tgt = lru_idx_q;
      OP_LOAD_FREE: tgt = stack_q[top_cnt[UNIT_W-1:0]];
      default:      tgt = hit_idx_q;
    endcase
    tgt_rank = rank_q[tgt];
  end

  // recency and occupancy update
  always_comb begin
    loaded_d   = loaded_q;
    free_cnt_d = free_cnt_q;
    units_d    = cmd_i.cfg_write ? cfg_capped : units_q;
    for (int i = 0; i < UNITS; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (refill) begin
      loaded_d   = '0;
      free_cnt_d = fill_n;
      for (int i = 0; i < UNITS; i++) begin
        rank_d[i] = '0;
      end
    end else begin
      case (cmd_i.op)
        OP_TOUCH, OP_EVICT, OP_LOAD_FREE: begin
          // everything younger than the target ages by one
          for (int i = 0; i < UNITS; i++) begin
            if (loaded_q[i] && (UNIT_W'(i) != tgt) &&
                ((cmd_i.op == OP_LOAD_FREE) || (rank_q[i] < tgt_rank))) begin
              rank_d[i] = rank_q[i] + UNIT_W'(1);
            end
          end
          rank_d[tgt]   = '0;
          loaded_d[tgt] = 1'b1;
          if (cmd_i.op == OP_LOAD_FREE) free_cnt_d = top_cnt;
        end
        OP_RELEASE: begin
          // close the gap left by the freed unit
          for (int i = 0; i < UNITS; i++) begin
            if (loaded_q[i] && (UNIT_W'(i) != tgt) && (rank_q[i] > tgt_rank)) begin
              rank_d[i] = rank_q[i] - UNIT_W'(1);
            end
          end
          rank_d[tgt]   = '0;
          loaded_d[tgt] = 1'b0;
          if (push_ok) free_cnt_d = free_cnt_q + CNT_W'(1);
        end
        default: begin
          loaded_d = loaded_q;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q   <= '0;
      free_cnt_q <= '0;
      units_q    <= '0;
      for (int i = 0; i < UNITS; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      loaded_q   <= loaded_d;
      free_cnt_q <= free_cnt_d;
      units_q    <= units_d;
      for (int i = 0; i < UNITS; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // request capture and lookup registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_e'(func_i);
      id_q   <= texture_id_i;
    end
    if (cmd_i.lookup) begin
      hit_idx_q <= hit_idx_c;
      lru_idx_q <= lru_idx_c;
      hit_any_q <= |hit_vec;
    end
  end

  // texture tags and free stack
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EVICT || cmd_i.op == OP_LOAD_FREE) begin
      tex_q[tgt] <= id_q;
    end
    if (refill) begin
      for (int i = 0; i < UNITS; i++) begin
        stack_q[i] <= UNIT_W'(fill_n - CNT_W'(1) - CNT_W'(i));
      end
    end else if (cmd_i.op == OP_RELEASE && push_ok) begin
      stack_q[free_cnt_q[UNIT_W-1:0]] <= tgt;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.op != OP_IDLE) begin
      unit_q   <= '0;
      hit_q    <= 1'b0;
      ev_q     <= 1'b0;
      evtex_q  <= '0;
      status_q <= cmd_i.status;
      case (cmd_i.op)
        OP_TOUCH: begin
          unit_q <= tgt;
          hit_q  <= 1'b1;
        end
        OP_EVICT: begin
          unit_q  <= tgt;
          ev_q    <= 1'b1;
          evtex_q <= tex_q[tgt];
        end
        OP_LOAD_FREE, OP_RELEASE: begin
          unit_q <= tgt;
        end
        default: begin
          unit_q <= '0;
        end
      endcase
    end
  end

  assign stat_o.func        = func_q;
  assign stat_o.not_init    = (units_q == '0);
  assign stat_o.hit         = hit_any_q;
  assign stat_o.stack_empty = (free_cnt_q == '0);

  assign unit_o            = unit_q;
  assign hit_o             = hit_q;
  assign evicted_o         = ev_q;
  assign evicted_texture_o = evtex_q;
  assign status_o          = status_q;

  `LUA_ASSERT(a_hit_unique, $onehot0(hit_vec))
  `LUA_ASSERT(a_pool_count, ($countones(loaded_q) + 32'(free_cnt_q)) == 32'(units_q))

endmodule

// File: hdl/lru_unit_allocator.sv
// channel   | direction | handshake                     | word
// ----------+-----------+-------------------------------+---------------------------------
// request   | in        | start, busy                   | func_i, texture_id_i
// config    | in        | cfg_valid_i, cfg_ready_o      | cfg_units_in_use_i
// result    | out       | done_o (one-cycle strobe)     | unit_o, hit_o, evicted_o,
//           |           |                               | evicted_texture_o, status_o
//
// every request goes through capture, tag lookup, update and the result strobe, in that order
// the sequence is set by the controller, with one pass through the tag compare
// busy is high from the cycle after start until the result strobe has gone
// reset leaves the pool uninitialized (zero units); a config write refills it
// the result strobe lasts one cycle and cannot be held off by the receiver
module lru_unit_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [lua_pkg::FUNC_W-1:0]   func_i,
  input  logic [lua_pkg::ID_W-1:0]     texture_id_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lua_pkg::CNT_W-1:0]    cfg_units_in_use_i,
  output logic                         done_o,
  output logic [lua_pkg::UNIT_W-1:0]   unit_o,
  output logic                         hit_o,
  output logic                         evicted_o,
  output logic [lua_pkg::ID_W-1:0]     evicted_texture_o,
  output logic [lua_pkg::STATUS_W-1:0] status_o
);
  import lua_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer
  lua_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .done_o      (done_o)
  );

  // tags, ranks and free stack
  lua_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .func_i            (func_i),
    .texture_id_i      (texture_id_i),
    .cfg_units_i       (cfg_units_in_use_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .unit_o            (unit_o),
    .hit_o             (hit_o),
    .evicted_o         (evicted_o),
    .evicted_texture_o (evicted_texture_o),
    .status_o          (status_o)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lua_pkg::*;

  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PLAN_PHASES   = 11;
  localparam int EXTRA_PHASES  = 2;
  localparam int HOT_MAX       = 40;
  localparam int PRINT_CAP     = 40;

  // one bind request word
  typedef struct packed {
    func_e           func;
    logic [ID_W-1:0] tex;
  } bind_req_t;

  // one result word
  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              hit;
    logic              evicted;
    logic [ID_W-1:0]   evicted_tex;
    status_e           status;
  } alloc_result_t;

  // dut ports
  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                start              = 1'b0;
  logic                busy;
  logic [FUNC_W-1:0]   func_i             = FUNC_USE;
  logic [ID_W-1:0]     texture_id_i       = '0;
  logic                cfg_valid_i        = 1'b0;
  logic                cfg_ready_o;
  logic [CNT_W-1:0]    cfg_units_in_use_i = '0;
  logic                done_o;
  logic [UNIT_W-1:0]   unit_o;
  logic                hit_o;
  logic                evicted_o;
  logic [ID_W-1:0]     evicted_texture_o;
  logic [STATUS_W-1:0] status_o;

  lru_unit_allocator dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .func_i             (func_i),
    .texture_id_i       (texture_id_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_units_in_use_i (cfg_units_in_use_i),
    .done_o             (done_o),
    .unit_o             (unit_o),
    .hit_o              (hit_o),
    .evicted_o          (evicted_o),
    .evicted_texture_o  (evicted_texture_o),
    .status_o           (status_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the allocator state
  logic [CNT_W-1:0]  pool_cfg;
  logic [ID_W-1:0]   unit_tex   [UNITS];
  logic              unit_held  [UNITS];
  logic [UNIT_W-1:0] unit_age   [UNITS];
  logic [UNIT_W-1:0] free_units [UNITS];
  logic [CNT_W-1:0]  free_cnt;

  // request words waiting to go out, result words owed by the dut
  bind_req_t     bind_queue [$];
  alloc_result_t alloc_due  [$];

  bind_req_t     cur_req;
  alloc_result_t exp_res;
  alloc_result_t want;
  int            gap_left    = 0;
  bit            no_gaps     = 1'b0;
  int            stall_count = 0;

  int n_req      = 0;
  int n_hits     = 0;
  int n_evicts   = 0;
  int n_rejects  = 0;
  int n_cfg      = 0;
  int n_checked  = 0;
  int n_mismatch = 0;

  int unsigned pool_plan [PLAN_PHASES] = '{16, 1, 0, 4, 31, 3, 16, 8, 2, 17, 15};

  // sizes above the pool act as the full pool
  function automatic int pool_units();
    return (pool_cfg > UNITS) ? UNITS : int'(pool_cfg);
  endfunction

  // unload everything, stack refilled with unit 0 on top
  function automatic void refill_pool();
    int n;
    n = pool_units();
    for (int i = 0; i < UNITS; i++) begin
      unit_held[i] = 1'b0;
      unit_age[i]  = '0;
    end
    for (int i = 0; i < n; i++) free_units[i] = UNIT_W'(n - 1 - i);
    free_cnt = CNT_W'(n);
  endfunction

  // drop a unit and close the gap in the ages
  function automatic void unload_unit(int u);
    for (int i = 0; i < UNITS; i++)
      if (unit_held[i] && i != u && unit_age[i] > unit_age[u]) unit_age[i]--;
    unit_held[u] = 1'b0;
    unit_age[u]  = '0;
  endfunction

  // make a held unit the newest
  function automatic void touch_unit(int u);
    for (int i = 0; i < UNITS; i++)
      if (unit_held[i] && i != u && unit_age[i] < unit_age[u]) unit_age[i]++;
    unit_age[u] = '0;
  endfunction

  // bind an id to a unit as the newest
  function automatic void load_unit(int u, logic [ID_W-1:0] id);
    for (int i = 0; i < UNITS; i++)
      if (unit_held[i]) unit_age[i]++;
    unit_held[u] = 1'b1;
    unit_tex[u]  = id;
    unit_age[u]  = '0;
  endfunction

  function automatic int find_unit(logic [ID_W-1:0] id);
    int n;
    n = pool_units();
    for (int i = 0; i < n; i++)
      if (unit_held[i] && unit_tex[i] == id) return i;
    return -1;
  endfunction

  // expected result of one request, updates the shadow state
  function automatic alloc_result_t predict_alloc(bind_req_t req);
    alloc_result_t     res;
    int                n;
    int                f;
    int                victim;
    logic              found_old;
    logic [UNIT_W-1:0] oldest;
    res        = '0;
    res.status = STATUS_OK;
    n          = pool_units();
    if (req.func == FUNC_NOP) begin
      // ignored code, all fields zero
    end else if (n == 0) begin
      res.status = STATUS_NOT_INIT;
    end else if (req.func == FUNC_RELEASE_ALL) begin
      refill_pool();
    end else if (req.func == FUNC_RELEASE) begin
      f = find_unit(req.tex);
      if (f < 0) begin
        res.status = STATUS_NOT_LOADED;
      end else begin
        unload_unit(f);
        if (free_cnt < UNITS) begin
          free_units[free_cnt[UNIT_W-1:0]] = UNIT_W'(f);
          free_cnt++;
        end
        res.unit = UNIT_W'(f);
      end
    end else begin
      f = find_unit(req.tex);
      if (f >= 0) begin
        touch_unit(f);
        res.unit = UNIT_W'(f);
        res.hit  = 1'b1;
      end else begin
        victim = 0;
        if (free_cnt > 0) begin
          free_cnt--;
          victim = int'(free_units[free_cnt[UNIT_W-1:0]]);
        end else begin
          // no free unit: the oldest held unit goes
          found_old = 1'b0;
          oldest    = '0;
          for (int i = 0; i < n; i++)
            if (unit_held[i] && (!found_old || unit_age[i] > oldest)) begin
              oldest    = unit_age[i];
              victim    = i;
              found_old = 1'b1;
            end
          if (found_old) begin
            res.evicted     = 1'b1;
            res.evicted_tex = unit_tex[victim];
            unload_unit(victim);
          end
        end
        load_unit(victim, req.tex);
        res.unit = UNIT_W'(victim);
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] exp_val);
    if (n_mismatch < PRINT_CAP)
      $display("%0t mismatch on result %0d: %s got %0h want %0h",
               $time, n_checked, field, got, exp_val);
    n_mismatch++;
  endtask

  task automatic push_req(input func_e f, input logic [ID_W-1:0] id);
    bind_req_t req;
    req.func = f;
    req.tex  = id;
    bind_queue.push_back(req);
  endtask

  // wait until nothing is queued, in flight or owed, then let the block settle
  task automatic drain_pool();
    do @(negedge clk_i);
    while (bind_queue.size() != 0 || start || busy !== 1'b0 || alloc_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // register write, only while the block is idle
  task automatic set_pool_size(input logic [CNT_W-1:0] n);
    @(posedge clk_i);
    cfg_valid_i        <= 1'b1;
    cfg_units_in_use_i <= n;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    pool_cfg = n;
    refill_pool();
    n_cfg++;
    @(negedge clk_i);
  endtask

  // mostly a small hot set of ids so hits, releases and evictions happen
  task automatic queue_random(input int count, input int unsigned n);
    int              made;
    int              r;
    int              hot_cnt;
    int              lim;
    logic [ID_W-1:0] hot_ids [HOT_MAX];
    bind_req_t       req;
    lim = 2 * n + 2;
    if (lim > HOT_MAX) lim = HOT_MAX;
    hot_cnt = $urandom_range(1, lim);
    for (int i = 0; i < HOT_MAX; i++) hot_ids[i] = ID_W'($urandom);
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 66)      req.func = FUNC_USE;
      else if (r < 92) req.func = FUNC_RELEASE;
      else if (r < 96) req.func = FUNC_RELEASE_ALL;
      else             req.func = FUNC_NOP;
      if ($urandom_range(0, 4) == 0) req.tex = ID_W'($urandom);
      else                           req.tex = hot_ids[$urandom_range(0, hot_cnt - 1)];
      bind_queue.push_back(req);
      if (req.func != FUNC_NOP) made++;
    end
  endtask

  // request driver: presents the next word once the previous one is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        exp_res = predict_alloc(cur_req);
        alloc_due.push_back(exp_res);
        if (cur_req.func != FUNC_NOP) n_req++;
        if (exp_res.hit) n_hits++;
        if (exp_res.evicted) n_evicts++;
        if (exp_res.status == STATUS_NOT_LOADED) n_rejects++;
        // switch between gapped and back-to-back stretches now and then
        if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
        gap_left = no_gaps ? 0 : $urandom_range(0, 12);
      end
      if (!(start && busy)) begin
        if (gap_left == 0 && bind_queue.size() != 0) begin
          cur_req = bind_queue.pop_front();
          start        <= 1'b1;
          func_i       <= cur_req.func;
          texture_id_i <= cur_req.tex;
        end else begin
          start <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (alloc_due.size() == 0) begin
        flag_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        want = alloc_due.pop_front();
        n_checked++;
        if (unit_o !== want.unit) flag_mismatch("unit", 32'(unit_o), 32'(want.unit));
        if (hit_o !== want.hit) flag_mismatch("hit", 32'(hit_o), 32'(want.hit));
        if (evicted_o !== want.evicted)
          flag_mismatch("evicted", 32'(evicted_o), 32'(want.evicted));
        if (evicted_texture_o !== want.evicted_tex)
          flag_mismatch("evicted_texture", 32'(evicted_texture_o), 32'(want.evicted_tex));
        if (status_o !== want.status)
          flag_mismatch("status", 32'(status_o), 32'(want.status));
      end
    end
  end

  // watchdog on cycles where no word moves on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
        $display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  // stimulus sequence
  initial begin
    int unsigned n;
    pool_cfg = '0;
    refill_pool();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // pool not yet sized after reset
    push_req(FUNC_USE, 16'h1234);
    push_req(FUNC_RELEASE, 16'h1234);
    push_req(FUNC_RELEASE_ALL, 16'h0000);
    push_req(FUNC_NOP, 16'hFFFF);
    drain_pool();

    // two units: fill, hit, evict the oldest, release, reuse, empty all
    set_pool_size(CNT_W'(2));
    push_req(FUNC_USE, 16'h0000);
    push_req(FUNC_USE, 16'hFFFF);
    push_req(FUNC_USE, 16'h0000);
    push_req(FUNC_USE, 16'h8000);
    push_req(FUNC_RELEASE, 16'hABCD);
    push_req(FUNC_RELEASE, 16'h0000);
    push_req(FUNC_USE, 16'h0001);
    push_req(FUNC_USE, 16'h0001);
    push_req(FUNC_RELEASE_ALL, 16'h0000);
    push_req(FUNC_NOP, 16'h5A5A);
    push_req(FUNC_USE, 16'hFFFF);
    drain_pool();

    // oversized register value acts as the full pool
    set_pool_size(CNT_W'(31));
    push_req(FUNC_USE, 16'hFFFF);
    push_req(FUNC_USE, 16'h0000);
    push_req(FUNC_RELEASE, 16'hFFFF);
    push_req(FUNC_USE, 16'h1234);
    drain_pool();

    // random phases over several pool sizes
    for (int p = 0; p < PLAN_PHASES + EXTRA_PHASES; p++) begin
      n = (p < PLAN_PHASES) ? pool_plan[p] : $urandom_range(0, 31);
      set_pool_size(CNT_W'(n));
      queue_random((n == 0) ? 20 : 150, n);
      drain_pool();
    end

    $display("sent %0d requests over %0d pool sizes: %0d hits, %0d evictions, %0d stale releases",
             n_req, n_cfg, n_hits, n_evicts, n_rejects);
    $display("checked %0d results, %0d mismatches", n_checked, n_mismatch);
    if (n_mismatch == 0 && alloc_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: lru_unit_allocator.f
+incdir+hdl
hdl/lua_pkg.sv
hdl/lua_ctrl.sv
hdl/lua_datapath.sv
hdl/lru_unit_allocator.sv
tb/sv/testbench.sv
